### design/asig_pkg.sv
// asig_pkg: types, codes and reset values for the actuator safety gate
// no dependencies; imported by every module of the gate
`timescale 1ns / 1ps

package asig_pkg;

   // event codes
   localparam logic [2:0] OP_TICK        = 3'd0;
   localparam logic [2:0] OP_MODE        = 3'd1;
   localparam logic [2:0] OP_HEALTH      = 3'd2;
   localparam logic [2:0] OP_SWITCH_DONE = 3'd3;
   localparam logic [2:0] OP_POWER_DONE  = 3'd4;
   localparam logic [2:0] OP_JOINTS      = 3'd5;
   localparam logic [2:0] OP_TRAJECTORY  = 3'd6;

   // actions
   localparam logic [1:0] ACT_ENABLE     = 2'd0;
   localparam logic [1:0] ACT_HOLD       = 2'd1;
   localparam logic [1:0] ACT_TORQUE_OFF = 2'd2;

   // block reasons
   localparam logic [3:0] WHY_NONE           = 4'd0;
   localparam logic [3:0] WHY_NO_MODE        = 4'd1;
   localparam logic [3:0] WHY_MODE_TIMEOUT   = 4'd2;
   localparam logic [3:0] WHY_ESTOP          = 4'd3;
   localparam logic [3:0] WHY_NOT_ACTIVE     = 4'd4;
   localparam logic [3:0] WHY_NO_HEALTH      = 4'd5;
   localparam logic [3:0] WHY_HEALTH_TIMEOUT = 4'd6;
   localparam logic [3:0] WHY_UNHEALTHY      = 4'd7;

   // lifecycle requests
   localparam logic [2:0] REQ_NONE      = 3'd0;
   localparam logic [2:0] REQ_CTRL_OFF  = 3'd1;
   localparam logic [2:0] REQ_CTRL_ON   = 3'd2;
   localparam logic [2:0] REQ_POWER_ON  = 3'd3;
   localparam logic [2:0] REQ_POWER_OFF = 3'd4;

   // status codes
   localparam logic [1:0] STAT_ENABLED    = 2'd0;
   localparam logic [1:0] STAT_TRANSITION = 2'd1;
   localparam logic [1:0] STAT_TORQUE_OFF = 2'd2;
   localparam logic [1:0] STAT_HOLD       = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_MODE_TIMEOUT   = 3'd0;
   localparam logic [2:0] CSR_HEALTH_TIMEOUT = 3'd1;
   localparam logic [2:0] CSR_REQUIRE_HEALTH = 3'd2;
   localparam logic [2:0] CSR_MANAGE_LIFE    = 3'd3;
   localparam logic [2:0] CSR_TORQUE_OFF_TO  = 3'd4;
   localparam logic [2:0] CSR_ACTIVE_MODE    = 3'd5;
   localparam logic [2:0] CSR_ESTOP_MODE     = 3'd6;

   localparam int          CSR_INDEX_W = 3;
   localparam int          CSR_DATA_W  = 16;
   localparam logic [15:0] AGE_MAX     = 16'hFFFF;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] mode_value;
      logic       nav_good;
      logic       drives_good;
      logic       errors_empty;
      logic       response_ok;
      logic       switch_service_ready;
      logic       power_service_ready;
      logic       position_seen;
   } req_item_type;

   typedef struct packed {
      logic [1:0] action;
      logic [3:0] block_reason;
      logic       commands_on;
      logic       hold_pulse;
      logic [2:0] lifecycle_request;
      logic       forward_trajectory;
      logic [1:0] status_code;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] mode_timeout_ticks;
      logic [15:0] health_timeout_ticks;
      logic        require_health;
      logic        manage_lifecycle;
      logic        torque_off_on_timeout;
      logic [7:0]  active_mode_code;
      logic [7:0]  estop_mode_code;
   } cfg_type;

   typedef struct packed {
      logic        mode_received;
      logic        health_received;
      logic        health_good;
      logic [7:0]  current_mode;
      logic [15:0] mode_age;
      logic [15:0] health_age;
      logic        estop_latch;
      logic        enabled_flag;
      logic        hold_sent;
      logic        power_active;
      logic        controllers_on;
      logic        busy;
      logic [2:0]  pending_request;
      logic [1:0]  desired_action;
      logic [3:0]  reason_code;
      logic        positions_known;
   } state_type;

   localparam cfg_type CFG_RESET = '{
      mode_timeout_ticks:    16'd25,
      health_timeout_ticks:  16'd25,
      require_health:        1'b1,
      manage_lifecycle:      1'b1,
      torque_off_on_timeout: 1'b1,
      active_mode_code:      8'd1,
      estop_mode_code:       8'd3
   };

   localparam state_type STATE_RESET = '{
      mode_received:   1'b0,
      health_received: 1'b0,
      health_good:     1'b0,
      current_mode:    8'd0,
      mode_age:        16'd0,
      health_age:      16'd0,
      estop_latch:     1'b0,
      enabled_flag:    1'b0,
      hold_sent:       1'b0,
      power_active:    1'b0,
      controllers_on:  1'b0,
      busy:            1'b0,
      pending_request: REQ_NONE,
      desired_action:  ACT_TORQUE_OFF,
      reason_code:     WHY_NO_MODE,
      positions_known: 1'b0
   };

   // next lifecycle request the sequencer wants, REQ_NONE when none or service not ready
   function automatic logic [2:0] drive_request(
      input logic      manage,
      input state_type s,
      input logic      sw_ready,
      input logic      pw_ready
   );
      logic [2:0] req;
      req = REQ_NONE;
      if (manage && !s.busy) begin
         if (s.desired_action == ACT_TORQUE_OFF && s.power_active) begin
            if (sw_ready) req = REQ_CTRL_OFF;
         end else if (s.desired_action == ACT_ENABLE && !s.power_active) begin
            if (pw_ready) req = REQ_POWER_ON;
         end else if (s.desired_action == ACT_ENABLE && !s.controllers_on) begin
            if (sw_ready) req = REQ_CTRL_ON;
         end
      end
      return req;
   endfunction

endpackage

### design/arm_safety_interlock_gate_core.sv
// arm_safety_interlock_gate_core: top level of the actuator safety gate
// depends on asig_pkg, asig_csr, asig_eval
//
// channel | direction | ports                          | payload
// req     | in        | req_valid, req_ready           | req_item (req_item_type)
// rsp     | out       | rsp_valid, rsp_ready           | rsp_item (rsp_item_type)
// csr     | in        | csr_valid, csr_ready           | csr_index, csr_wdata
//
// every item's result is registered after the item is accepted: item register,
// then gate logic into the result register; one item per cycle sustained unless
// the result stalls; gate state is updated as an item moves into the result register
// a stalled result holds the item register, which still takes a new item when empty
// synchronous reset restores watchdogs, flags and configuration registers to their defaults
`timescale 1ns / 1ps

module arm_safety_interlock_gate_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  asig_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output asig_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [asig_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [asig_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import asig_pkg::*;

   cfg_type      cfg;
   state_type    st_ff;
   state_type    st_in;
   req_item_type req_item_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;
   logic         req_valid_ff;
   logic         rsp_valid_ff;
   logic         advance;

   asig_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   asig_eval u_eval (
      .cfg     (cfg),
      .st      (st_ff),
      .item    (req_item_ff),
      .st_next (st_in),
      .rsp     (rsp_item_in)
   );

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= STATE_RESET;
      end else begin
         if (req_ready) req_valid_ff <= req_valid;
         if (advance) begin
            st_ff        <= st_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_item_ff <= req_item;
      if (advance) rsp_item_ff <= rsp_item_in;
   end

   a_busy_pending: assert property (@(posedge clock) disable iff (reset)
      st_ff.busy == (st_ff.pending_request != REQ_NONE))
      else $error("busy flag and pending request disagree");

   a_enabled_action: assert property (@(posedge clock) disable iff (reset)
      st_ff.enabled_flag |-> st_ff.desired_action == ACT_ENABLE)
      else $error("commands enabled without enable action");

   a_pulse_hold: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_item_in.hold_pulse |=> rsp_item.action == ACT_HOLD && st_ff.hold_sent)
      else $error("hold pulse without hold action");

endmodule

### design/asig_csr.sv
// asig_csr: configuration registers of the safety gate, written by index
// depends on asig_pkg
`timescale 1ns / 1ps

module asig_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [asig_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [asig_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output asig_pkg::cfg_type                  cfg
);
   import asig_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE_TIMEOUT:   cfg_in.mode_timeout_ticks    = csr_wdata;
            CSR_HEALTH_TIMEOUT: cfg_in.health_timeout_ticks  = csr_wdata;
            CSR_REQUIRE_HEALTH: cfg_in.require_health        = csr_wdata[0];
            CSR_MANAGE_LIFE:    cfg_in.manage_lifecycle      = csr_wdata[0];
            CSR_TORQUE_OFF_TO:  cfg_in.torque_off_on_timeout = csr_wdata[0];
            CSR_ACTIVE_MODE:    cfg_in.active_mode_code      = csr_wdata[7:0];
            CSR_ESTOP_MODE:     cfg_in.estop_mode_code       = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/asig_eval.sv
// asig_eval: event decode, watchdog gate and lifecycle sequencing for one item
// depends on asig_pkg; purely combinational, sits between the item and result registers
`timescale 1ns / 1ps

module asig_eval (
   input  asig_pkg::cfg_type      cfg,
   input  asig_pkg::state_type    st,
   input  asig_pkg::req_item_type item,
   output asig_pkg::state_type    st_next,
   output asig_pkg::rsp_item_type rsp
);
   import asig_pkg::*;

   state_type  ns;
   logic       do_eval;
   logic       pulse;
   logic [2:0] issued;
   logic [2:0] req;
   logic       ctrl_on;
   logic [1:0] act;
   logic [3:0] why;
   logic [1:0] status;

   always_comb begin
      ns      = st;
      do_eval = 1'b0;
      pulse   = 1'b0;
      issued  = REQ_NONE;
      req     = REQ_NONE;
      ctrl_on = 1'b0;
      act     = ACT_HOLD;
      why     = WHY_NONE;

      case (item.op)
         OP_TICK: begin
            if (ns.mode_age != AGE_MAX) ns.mode_age = ns.mode_age + 16'd1;
            if (ns.health_age != AGE_MAX) ns.health_age = ns.health_age + 16'd1;
            do_eval = 1'b1;
         end
         OP_MODE: begin
            ns.mode_received = 1'b1;
            ns.current_mode  = item.mode_value;
            ns.mode_age      = '0;
            if (item.mode_value == cfg.estop_mode_code) ns.estop_latch = 1'b1;
            do_eval = 1'b1;
         end
         OP_HEALTH: begin
            ns.health_received = 1'b1;
            ns.health_good = item.nav_good & item.drives_good & item.errors_empty;
            ns.health_age  = '0;
            do_eval = 1'b1;
         end
         OP_SWITCH_DONE: begin
            if (st.busy && (st.pending_request == REQ_CTRL_OFF ||
                            st.pending_request == REQ_CTRL_ON)) begin
               ctrl_on            = (st.pending_request == REQ_CTRL_ON);
               ns.busy            = 1'b0;
               ns.pending_request = REQ_NONE;
               if (item.response_ok) begin
                  ns.controllers_on = ctrl_on;
                  if (!ctrl_on && ns.desired_action == ACT_TORQUE_OFF) begin
                     if (item.power_service_ready) begin
                        ns.busy            = 1'b1;
                        ns.pending_request = REQ_POWER_OFF;
                        issued             = REQ_POWER_OFF;
                     end
                  end else begin
                     ns.enabled_flag = ctrl_on && ns.desired_action == ACT_ENABLE;
                     req = drive_request(cfg.manage_lifecycle, ns,
                                         item.switch_service_ready,
                                         item.power_service_ready);
                  end
               end
            end
         end
         OP_POWER_DONE: begin
            if (st.busy && (st.pending_request == REQ_POWER_ON ||
                            st.pending_request == REQ_POWER_OFF)) begin
               ns.busy            = 1'b0;
               ns.pending_request = REQ_NONE;
               if (item.response_ok) begin
                  ns.power_active = (st.pending_request == REQ_POWER_ON);
                  if (st.pending_request != REQ_POWER_ON) ns.enabled_flag = 1'b0;
                  req = drive_request(cfg.manage_lifecycle, ns,
                                      item.switch_service_ready,
                                      item.power_service_ready);
               end
            end
         end
         OP_JOINTS: begin
            if (item.position_seen) ns.positions_known = 1'b1;
         end
         OP_TRAJECTORY: begin
            do_eval = 1'b1;
         end
         default: begin
            ns = st;
         end
      endcase

      if (do_eval) begin
         if (!ns.mode_received) begin
            why = WHY_NO_MODE;
            act = ACT_TORQUE_OFF;
         end else if (ns.mode_age > cfg.mode_timeout_ticks) begin
            why = WHY_MODE_TIMEOUT;
            act = cfg.torque_off_on_timeout ? ACT_TORQUE_OFF : ACT_HOLD;
         end else if (ns.current_mode == cfg.estop_mode_code) begin
            why = WHY_ESTOP;
            act = ACT_TORQUE_OFF;
         end else if (ns.current_mode != cfg.active_mode_code) begin
            why = WHY_NOT_ACTIVE;
         end else if (cfg.require_health && !ns.health_received) begin
            why = WHY_NO_HEALTH;
         end else if (cfg.require_health && ns.health_age > cfg.health_timeout_ticks) begin
            why = WHY_HEALTH_TIMEOUT;
         end else if (cfg.require_health && !ns.health_good) begin
            why = WHY_UNHEALTHY;
         end else begin
            act            = ACT_ENABLE;
            ns.estop_latch = 1'b0;
         end

         if (ns.estop_latch && act != ACT_ENABLE) act = ACT_TORQUE_OFF;

         ns.desired_action = act;
         ns.reason_code    = (act == ACT_ENABLE) ? WHY_NONE : why;
         ns.enabled_flag   = act == ACT_ENABLE &&
                             (!cfg.manage_lifecycle || ns.power_active) && !ns.busy;

         if (act == ACT_HOLD && ns.power_active) begin
            if (!ns.hold_sent && ns.positions_known) begin
               pulse        = 1'b1;
               ns.hold_sent = 1'b1;
            end
         end else if (act != ACT_HOLD) begin
            ns.hold_sent = 1'b0;
         end

         req = drive_request(cfg.manage_lifecycle, ns,
                             item.switch_service_ready, item.power_service_ready);
      end

      if (req != REQ_NONE) begin
         ns.busy            = 1'b1;
         ns.pending_request = req;
         issued             = req;
      end

      if (ns.enabled_flag)      status = STAT_ENABLED;
      else if (ns.busy)         status = STAT_TRANSITION;
      else if (!ns.power_active) status = STAT_TORQUE_OFF;
      else                      status = STAT_HOLD;

      st_next                = ns;
      rsp.action             = ns.desired_action;
      rsp.block_reason       = ns.reason_code;
      rsp.commands_on        = ns.enabled_flag;
      rsp.hold_pulse         = pulse;
      rsp.lifecycle_request  = issued;
      rsp.forward_trajectory = (item.op == OP_TRAJECTORY) && ns.enabled_flag;
      rsp.status_code        = status;
   end

endmodule

### sim/asig_gate_checker.sv
// asig_gate_checker: watches the req, rsp and csr channels of the safety gate,
// predicts one result per accepted item and compares it with the block's output
// depends on asig_pkg
`timescale 1ns / 1ps

module asig_gate_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  asig_pkg::req_item_type             req_item,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  asig_pkg::rsp_item_type             rsp_item,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [asig_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [asig_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 fail_count,
   output int                                 items_outstanding
);
   import asig_pkg::*;

   cfg_type      gate_cfg;
   rsp_item_type expected_rsp [$];
   rsp_item_type want_rsp;
   rsp_item_type next_rsp;

   logic        mode_seen, health_seen, health_fine, estop_held;
   logic        cmd_on, hold_done, power_on, ctrl_on, busy_q, pos_known;
   logic [7:0]  mode_q;
   logic [15:0] mode_age_q, health_age_q;
   logic [2:0]  pend_req, issued;
   logic [1:0]  act_q;
   logic [3:0]  why_q;
   logic        pulse;

   task automatic reset_model();
      gate_cfg     = CFG_RESET;
      mode_seen    = 1'b0;
      health_seen  = 1'b0;
      health_fine  = 1'b0;
      estop_held   = 1'b0;
      cmd_on       = 1'b0;
      hold_done    = 1'b0;
      power_on     = 1'b0;
      ctrl_on      = 1'b0;
      busy_q       = 1'b0;
      pos_known    = 1'b0;
      mode_q       = 8'd0;
      mode_age_q   = 16'd0;
      health_age_q = 16'd0;
      pend_req     = REQ_NONE;
      act_q        = ACT_TORQUE_OFF;
      why_q        = WHY_NO_MODE;
      issued       = REQ_NONE;
      pulse        = 1'b0;
   endtask

   task automatic ask_controllers(input logic want_on, input logic ready);
      if (ready) begin
         busy_q   = 1'b1;
         pend_req = want_on ? REQ_CTRL_ON : REQ_CTRL_OFF;
         issued   = pend_req;
      end
   endtask

   task automatic ask_power(input logic want_on, input logic ready);
      if (ready) begin
         busy_q   = 1'b1;
         pend_req = want_on ? REQ_POWER_ON : REQ_POWER_OFF;
         issued   = pend_req;
      end
   endtask

   task automatic sequence_lifecycle(input logic sw_ready, input logic pw_ready);
      if (gate_cfg.manage_lifecycle && !busy_q) begin
         if (act_q == ACT_TORQUE_OFF && power_on) begin
            ask_controllers(1'b0, sw_ready);
         end else if (act_q == ACT_ENABLE && !power_on) begin
            ask_power(1'b1, pw_ready);
         end else if (act_q == ACT_ENABLE && !ctrl_on) begin
            ask_controllers(1'b1, sw_ready);
         end
      end
   endtask

   task automatic gate_update(input logic sw_ready, input logic pw_ready);
      logic [1:0] act;
      logic [3:0] why;
      act = ACT_HOLD;
      why = WHY_NONE;
      if (!mode_seen) begin
         why = WHY_NO_MODE;
         act = ACT_TORQUE_OFF;
      end else if (mode_age_q > gate_cfg.mode_timeout_ticks) begin
         why = WHY_MODE_TIMEOUT;
         act = gate_cfg.torque_off_on_timeout ? ACT_TORQUE_OFF : ACT_HOLD;
      end else if (mode_q == gate_cfg.estop_mode_code) begin
         why = WHY_ESTOP;
         act = ACT_TORQUE_OFF;
      end else if (mode_q != gate_cfg.active_mode_code) begin
         why = WHY_NOT_ACTIVE;
      end else if (gate_cfg.require_health && !health_seen) begin
         why = WHY_NO_HEALTH;
      end else if (gate_cfg.require_health && health_age_q > gate_cfg.health_timeout_ticks) begin
         why = WHY_HEALTH_TIMEOUT;
      end else if (gate_cfg.require_health && !health_fine) begin
         why = WHY_UNHEALTHY;
      end else begin
         act        = ACT_ENABLE;
         estop_held = 1'b0;
      end
      if (estop_held && act != ACT_ENABLE) act = ACT_TORQUE_OFF;
      act_q  = act;
      why_q  = (act == ACT_ENABLE) ? WHY_NONE : why;
      cmd_on = (act == ACT_ENABLE) && (!gate_cfg.manage_lifecycle || power_on) && !busy_q;
      if (act == ACT_HOLD && power_on) begin
         if (!hold_done && pos_known) begin
            pulse     = 1'b1;
            hold_done = 1'b1;
         end
      end else if (act != ACT_HOLD) begin
         hold_done = 1'b0;
      end
      sequence_lifecycle(sw_ready, pw_ready);
   endtask

   task automatic predict_result(input req_item_type it, output rsp_item_type r);
      logic want_on;
      logic fwd;
      issued = REQ_NONE;
      pulse  = 1'b0;
      fwd    = 1'b0;
      case (it.op)
         OP_TICK: begin
            if (mode_age_q != AGE_MAX) mode_age_q = mode_age_q + 16'd1;
            if (health_age_q != AGE_MAX) health_age_q = health_age_q + 16'd1;
            gate_update(it.switch_service_ready, it.power_service_ready);
         end
         OP_MODE: begin
            mode_seen  = 1'b1;
            mode_q     = it.mode_value;
            mode_age_q = 16'd0;
            if (mode_q == gate_cfg.estop_mode_code) estop_held = 1'b1;
            gate_update(it.switch_service_ready, it.power_service_ready);
         end
         OP_HEALTH: begin
            health_seen  = 1'b1;
            health_fine  = it.nav_good && it.drives_good && it.errors_empty;
            health_age_q = 16'd0;
            gate_update(it.switch_service_ready, it.power_service_ready);
         end
         OP_SWITCH_DONE: begin
            if (busy_q && (pend_req == REQ_CTRL_OFF || pend_req == REQ_CTRL_ON)) begin
               want_on  = (pend_req == REQ_CTRL_ON);
               busy_q   = 1'b0;
               pend_req = REQ_NONE;
               if (it.response_ok) begin
                  ctrl_on = want_on;
                  if (!want_on && act_q == ACT_TORQUE_OFF) begin
                     ask_power(1'b0, it.power_service_ready);
                  end else begin
                     cmd_on = want_on && (act_q == ACT_ENABLE);
                     sequence_lifecycle(it.switch_service_ready, it.power_service_ready);
                  end
               end
            end
         end
         OP_POWER_DONE: begin
            if (busy_q && (pend_req == REQ_POWER_ON || pend_req == REQ_POWER_OFF)) begin
               want_on  = (pend_req == REQ_POWER_ON);
               busy_q   = 1'b0;
               pend_req = REQ_NONE;
               if (it.response_ok) begin
                  power_on = want_on;
                  if (!want_on) cmd_on = 1'b0;
                  sequence_lifecycle(it.switch_service_ready, it.power_service_ready);
               end
            end
         end
         OP_JOINTS: begin
            if (it.position_seen) pos_known = 1'b1;
         end
         OP_TRAJECTORY: begin
            gate_update(it.switch_service_ready, it.power_service_ready);
            fwd = cmd_on;
         end
         default: ;
      endcase
      r.action             = act_q;
      r.block_reason       = why_q;
      r.commands_on        = cmd_on;
      r.hold_pulse         = pulse;
      r.lifecycle_request  = issued;
      r.forward_trajectory = fwd;
      if (cmd_on) r.status_code = STAT_ENABLED;
      else if (busy_q) r.status_code = STAT_TRANSITION;
      else if (!power_on) r.status_code = STAT_TORQUE_OFF;
      else r.status_code = STAT_HOLD;
   endtask

   function automatic int field_differs(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: result expected none, got %h", $time, rsp_item);
               fail_count = fail_count + 1;
            end else begin
               want_rsp   = expected_rsp.pop_front();
               fail_count = fail_count
                  + field_differs("action", want_rsp.action, rsp_item.action)
                  + field_differs("block_reason", want_rsp.block_reason, rsp_item.block_reason)
                  + field_differs("commands_on", want_rsp.commands_on, rsp_item.commands_on)
                  + field_differs("hold_pulse", want_rsp.hold_pulse, rsp_item.hold_pulse)
                  + field_differs("lifecycle_request", want_rsp.lifecycle_request,
                                  rsp_item.lifecycle_request)
                  + field_differs("forward_trajectory", want_rsp.forward_trajectory,
                                  rsp_item.forward_trajectory)
                  + field_differs("status_code", want_rsp.status_code, rsp_item.status_code);
            end
         end
         if (req_valid && req_ready) begin
            predict_result(req_item, next_rsp);
            expected_rsp.insert(expected_rsp.size(), next_rsp);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE_TIMEOUT:   gate_cfg.mode_timeout_ticks    = csr_wdata;
               CSR_HEALTH_TIMEOUT: gate_cfg.health_timeout_ticks  = csr_wdata;
               CSR_REQUIRE_HEALTH: gate_cfg.require_health        = csr_wdata[0];
               CSR_MANAGE_LIFE:    gate_cfg.manage_lifecycle      = csr_wdata[0];
               CSR_TORQUE_OFF_TO:  gate_cfg.torque_off_on_timeout = csr_wdata[0];
               CSR_ACTIVE_MODE:    gate_cfg.active_mode_code      = csr_wdata[7:0];
               CSR_ESTOP_MODE:     gate_cfg.estop_mode_code       = csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      items_outstanding = expected_rsp.size();
   end

endmodule

### sim/arm_safety_interlock_gate_core_test.sv
// arm_safety_interlock_gate_core_test: drives events and register writes into the
// safety gate with random idling and back-pressure; asig_gate_checker judges results
// depends on asig_pkg, asig_gate_checker and arm_safety_interlock_gate_core
`timescale 1ns / 1ps

module arm_safety_interlock_gate_core_test;
   import asig_pkg::*;

   localparam logic [2:0] OP_UNUSED       = 3'd7;
   localparam int         STALL_LIMIT     = 3000;
   localparam int         HOLD_OFF_CYCLES = 300;
   localparam int         SOAK_TICKS      = 10;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   req_item_type            req_item;
   logic                    rsp_valid;
   logic                    rsp_ready;
   rsp_item_type            rsp_item;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   int      fail_count;
   int      items_outstanding;
   int      idle_cycles;
   logic    quiet;
   logic    hold_off_flip;
   logic    hold_off_seen;
   cfg_type cur_cfg;

   arm_safety_interlock_gate_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   asig_gate_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_item          (req_item),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_item          (rsp_item),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .items_outstanding (items_outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready     = 1'b0;
      hold_off_seen = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_flip != hold_off_seen) begin
            hold_off_seen = hold_off_flip;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_ready <= quiet || ($urandom_range(99) >= 33);
      end
   end

   function automatic req_item_type compose_event(input logic [2:0] op, input logic [7:0] mv,
                                                  input logic [2:0] health, input logic resp,
                                                  input logic [1:0] ready, input logic pos);
      req_item_type it;
      it.op                   = op;
      it.mode_value           = mv;
      it.nav_good             = health[2];
      it.drives_good          = health[1];
      it.errors_empty         = health[0];
      it.response_ok          = resp;
      it.switch_service_ready = ready[1];
      it.power_service_ready  = ready[0];
      it.position_seen        = pos;
      return it;
   endfunction

   function automatic req_item_type random_event(input cfg_type c);
      logic [2:0] op;
      logic [7:0] mv;
      logic [2:0] health;
      int         pick;
      pick = $urandom_range(99);
      if (pick < 24) op = OP_TICK;
      else if (pick < 39) op = OP_MODE;
      else if (pick < 53) op = OP_HEALTH;
      else if (pick < 66) op = OP_SWITCH_DONE;
      else if (pick < 79) op = OP_POWER_DONE;
      else if (pick < 84) op = OP_JOINTS;
      else if (pick < 98) op = OP_TRAJECTORY;
      else op = OP_UNUSED;
      pick = $urandom_range(99);
      if (pick < 55) mv = c.active_mode_code;
      else if (pick < 70) mv = c.estop_mode_code;
      else mv = 8'($urandom_range(255));
      health = ($urandom_range(99) < 75) ? 3'b111 : 3'($urandom_range(7));
      return compose_event(op, mv, health, $urandom_range(99) < 85,
                           {$urandom_range(99) < 85, $urandom_range(99) < 85},
                           1'($urandom_range(1)));
   endfunction

   task automatic send_event(input req_item_type it);
      while (!quiet && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value, input int width);
      logic [31:0] wide;
      logic [31:0] junk;
      logic [15:0] mask;
      wide = (32'd1 << width) - 32'd1;
      mask = wide[15:0];
      junk = $urandom;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= (junk[15:0] & ~mask) | (value & mask);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (items_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_gate(input cfg_type c);
      settle();
      write_reg(CSR_MODE_TIMEOUT, c.mode_timeout_ticks, 16);
      write_reg(CSR_HEALTH_TIMEOUT, c.health_timeout_ticks, 16);
      write_reg(CSR_REQUIRE_HEALTH, {15'd0, c.require_health}, 1);
      write_reg(CSR_MANAGE_LIFE, {15'd0, c.manage_lifecycle}, 1);
      write_reg(CSR_TORQUE_OFF_TO, {15'd0, c.torque_off_on_timeout}, 1);
      write_reg(CSR_ACTIVE_MODE, {8'd0, c.active_mode_code}, 8);
      write_reg(CSR_ESTOP_MODE, {8'd0, c.estop_mode_code}, 8);
      cur_cfg = c;
   endtask

   function automatic cfg_type make_cfg(input logic [15:0] mt, input logic [15:0] ht,
                                        input logic rh, input logic ml, input logic to,
                                        input logic [7:0] am, input logic [7:0] em);
      cfg_type c;
      c.mode_timeout_ticks    = mt;
      c.health_timeout_ticks  = ht;
      c.require_health        = rh;
      c.manage_lifecycle      = ml;
      c.torque_off_on_timeout = to;
      c.active_mode_code      = am;
      c.estop_mode_code       = em;
      return c;
   endfunction

   task automatic random_run(input int count, input int hold_off_at);
      for (int i = 0; i < count; i++) begin
         if (i == hold_off_at) hold_off_flip = ~hold_off_flip;
         send_event(random_event(cur_cfg));
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_item      = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      quiet         = 1'b0;
      hold_off_flip = 1'b0;
      cur_cfg       = CFG_RESET;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // power-up sequence, hold pulse, estop latch and failed or stray completions
      send_event(compose_event(OP_TICK,        8'd0,   3'b111, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_TRAJECTORY,  8'd0,   3'b000, 1'b0, 2'b00, 1'b0));
      send_event(compose_event(OP_JOINTS,      8'd0,   3'b000, 1'b0, 2'b11, 1'b0));
      send_event(compose_event(OP_MODE,        8'hFF,  3'b000, 1'b0, 2'b11, 1'b0));
      send_event(compose_event(OP_JOINTS,      8'd0,   3'b000, 1'b0, 2'b11, 1'b1));
      send_event(compose_event(OP_MODE,        8'd1,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_HEALTH,      8'd0,   3'b111, 1'b1, 2'b10, 1'b0));
      send_event(compose_event(OP_TICK,        8'd0,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_POWER_DONE,  8'd0,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_SWITCH_DONE, 8'd0,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_TRAJECTORY,  8'd0,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_HEALTH,      8'd0,   3'b011, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_HEALTH,      8'd0,   3'b101, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_HEALTH,      8'd0,   3'b110, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_HEALTH,      8'd0,   3'b111, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_MODE,        8'd3,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_SWITCH_DONE, 8'd0,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_MODE,        8'd0,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_POWER_DONE,  8'd0,   3'b000, 1'b0, 2'b11, 1'b0));
      send_event(compose_event(OP_POWER_DONE,  8'd0,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_TICK,        8'd0,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_SWITCH_DONE, 8'd0,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_POWER_DONE,  8'd0,   3'b000, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_UNUSED,      8'hFF,  3'b111, 1'b1, 2'b11, 1'b1));
      send_event(compose_event(OP_MODE,        8'd1,   3'b000, 1'b1, 2'b11, 1'b0));

      program_gate(make_cfg(16'd25, 16'd25, 1'b1, 1'b1, 1'b1, 8'd1, 8'd3));
      random_run(260, 60);
      program_gate(make_cfg(16'd1, 16'd1, 1'b0, 1'b1, 1'b0, 8'd0, 8'd255));
      random_run(250, -1);
      program_gate(make_cfg(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1, 8'd255, 8'd0));
      random_run(250, -1);
      program_gate(make_cfg(16'd3, 16'd2, 1'b1, 1'b1, 1'b0, 8'd7, 8'd7));
      random_run(250, -1);
      program_gate(make_cfg(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                            1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 8'($urandom_range(255)),
                            8'($urandom_range(255))));
      quiet = 1'b1;
      random_run(150, -1);
      quiet = 1'b0;
      random_run(100, -1);
      program_gate(make_cfg(16'd12, 16'd4, 1'b1, 1'b1, 1'b1, 8'($urandom_range(255)),
                            8'($urandom_range(255))));
      random_run(250, -1);

      // ticks against the largest timeouts
      program_gate(make_cfg(16'hFFFE, 16'hFFFF, 1'b1, 1'b1, 1'b1, 8'd1, 8'd3));
      quiet = 1'b1;
      send_event(compose_event(OP_MODE,   8'd1, 3'b111, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_HEALTH, 8'd0, 3'b111, 1'b1, 2'b11, 1'b0));
      for (int i = 0; i < SOAK_TICKS; i++) begin
         send_event(compose_event(OP_TICK, 8'($urandom_range(255)), 3'($urandom_range(7)),
                                  1'($urandom_range(1)), 2'($urandom_range(3)),
                                  1'($urandom_range(1))));
      end
      send_event(compose_event(OP_TRAJECTORY, 8'd0, 3'b111, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_MODE,       8'd1, 3'b111, 1'b1, 2'b11, 1'b0));
      send_event(compose_event(OP_TRAJECTORY, 8'd0, 3'b111, 1'b1, 2'b11, 1'b0));
      quiet = 1'b0;

      settle();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
